// ===== rtl/lsda_call_site_search_defines.svh =====
// assertion macros for the call-site search block
`ifndef LSDA_CALL_SITE_SEARCH_DEFINES_SVH
`define LSDA_CALL_SITE_SEARCH_DEFINES_SVH

// plain implication checked on every clock edge out of reset
`define LCS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lcs check failed");

// implication checked in the next cycle
`define LCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lcs check failed");

`endif

// ===== rtl/lcs_pkg.sv =====
`timescale 1ns / 1ps
package lcs_pkg;

  localparam int unsigned PointerBytesDefault = 8;
  localparam int unsigned QueueDepth = 2;

  localparam logic [1:0] OutContinue    = 2'd0;
  localparam logic [1:0] OutHandler     = 2'd1;
  localparam logic [1:0] OutInstall     = 2'd2;
  localparam logic [1:0] OutUnsupported = 2'd3;

  localparam logic [7:0] EncOmit    = 8'hff;
  localparam logic [7:0] EncUleb    = 8'h01;
  localparam logic [3:0] FmtPtr     = 4'h0;
  localparam logic [3:0] FmtUleb    = 4'h1;
  localparam logic [3:0] FmtU2      = 4'h2;
  localparam logic [3:0] FmtU4      = 4'h3;
  localparam logic [3:0] FmtU8      = 4'h4;
  localparam logic [3:0] FmtS2      = 4'hA;
  localparam logic [3:0] FmtS4      = 4'hB;
  localparam logic [3:0] FmtS8      = 4'hC;
  localparam logic [2:0] RelAbs     = 3'd0;
  localparam logic [2:0] RelPc      = 3'd1;

  typedef struct packed {
    logic        action;
    logic [7:0]  data_byte;
    logic [63:0] return_address;
    logic [63:0] region_start;
    logic [63:0] lsda_address;
    logic        lsda_present;
    logic [63:0] exc_class;
    logic [63:0] exception_handle;
    logic        search_phase;
  } lcs_in_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [63:0] landing_pad;
    logic [63:0] handler_data;
  } lcs_out_t;

  // what the front stage passes on: a classified start or a byte
  typedef struct packed {
    logic        is_start;
    logic        start_ok;
    logic [7:0]  data_byte;
    logic [63:0] lsda_address;
    logic [63:0] handle;
    logic        search_phase;
    logic [63:0] pc_offset;
    logic [63:0] region_start;
  } lcs_cmd_t;

  function automatic logic enc_ok(input logic [7:0] e);
    logic [3:0] lo;
    logic       fmt_ok;
    lo = e[3:0];
    fmt_ok = (lo <= FmtU8) || (lo == FmtS2) || (lo == FmtS4) || (lo == FmtS8);
    if (e == EncOmit) return 1'b1;
    return fmt_ok && ((e[6:4] == RelAbs) || (e[6:4] == RelPc));
  endfunction

  function automatic logic [3:0] fixed_size(input logic [7:0] e, input logic [3:0] pb);
    case (e[3:0])
      FmtPtr:        return pb;
      FmtU2, FmtS2:  return 4'd2;
      FmtU4, FmtS4:  return 4'd4;
      FmtU8, FmtS8:  return 4'd8;
      default:       return 4'd0;
    endcase
  endfunction

endpackage

// ===== rtl/lcs_front.sv =====
`timescale 1ns / 1ps
module lcs_front import lcs_pkg::*; #(
  parameter int unsigned POINTER_BYTES = PointerBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] own_class_i,
  input  logic        in_valid_i,
  input  lcs_in_t     in_data_i,
  output logic        in_stall_o,
  output logic        cmd_valid_o,
  output lcs_cmd_t    cmd_data_o,
  input  logic        cmd_ready_i
);

  localparam logic [63:0] PtrMask =
    (POINTER_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * POINTER_BYTES)) - 64'd1);
  localparam int unsigned IdxW = $clog2(QueueDepth);

  lcs_cmd_t           fifo_q [QueueDepth];
  logic [IdxW-1:0]    wr_q, rd_q;
  logic [IdxW:0]      cnt_q;
  logic               push, pop;
  lcs_cmd_t           cmd;

  always_comb begin
    cmd.is_start     = ~in_data_i.action;
    cmd.start_ok     = (in_data_i.exc_class == own_class_i) & in_data_i.lsda_present;
    cmd.data_byte    = in_data_i.data_byte;
    cmd.lsda_address = in_data_i.lsda_address & PtrMask;
    cmd.handle       = in_data_i.exception_handle;
    cmd.search_phase = in_data_i.search_phase;
    cmd.pc_offset    = (in_data_i.return_address - 64'd1 - in_data_i.region_start) & PtrMask;
    cmd.region_start = in_data_i.region_start & PtrMask;
  end

  assign in_stall_o  = (cnt_q == (IdxW+1)'(QueueDepth));
  assign push        = in_valid_i & ~in_stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_valid_o & cmd_ready_i;
  assign cmd_data_o  = fifo_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_q] <= cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == IdxW'(QueueDepth - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == IdxW'(QueueDepth - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (IdxW+1)'(push) - (IdxW+1)'(pop);
    end
  end

endmodule

// ===== rtl/lcs_back.sv =====
`timescale 1ns / 1ps
module lcs_back import lcs_pkg::*; #(
  parameter int unsigned POINTER_BYTES = PointerBytesDefault
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     cmd_valid_i,
  input  lcs_cmd_t cmd_data_i,
  output logic     cmd_ready_o,
  output logic     out_valid_o,
  output lcs_out_t out_data_o,
  input  logic     out_stall_i
);

  localparam logic [63:0] PtrMask =
    (POINTER_BYTES >= 8) ? {64{1'b1}} : ((64'd1 << (8 * POINTER_BYTES)) - 64'd1);
  localparam logic [3:0] PtrBytes = 4'(POINTER_BYTES);

  localparam logic [3:0] PhIdle   = 4'd0;
  localparam logic [3:0] PhLpEnc  = 4'd1;
  localparam logic [3:0] PhLpPtr  = 4'd2;
  localparam logic [3:0] PhTtEnc  = 4'd3;
  localparam logic [3:0] PhTtSkip = 4'd4;
  localparam logic [3:0] PhCsEnc  = 4'd5;
  localparam logic [3:0] PhCsLen  = 4'd6;
  localparam logic [3:0] PhEStart = 4'd7;
  localparam logic [3:0] PhELen   = 4'd8;
  localparam logic [3:0] PhEPad   = 4'd9;
  localparam logic [3:0] PhEAct   = 4'd10;

  logic [3:0]  phase_q, phase_d;
  logic [31:0] off_q, off_d;
  logic [63:0] acc_q, acc_d;
  logic [6:0]  shift_q, shift_d;
  logic [3:0]  left_q, left_d;
  logic [31:0] fstart_q, fstart_d;
  logic [7:0]  base_enc_q, base_enc_d;
  logic [7:0]  site_enc_q, site_enc_d;
  logic [63:0] pad_base_q, pad_base_d;
  logic [31:0] tend_q, tend_d;
  logic [63:0] estart_q, estart_d;
  logic [63:0] elen_q, elen_d;
  logic [63:0] pc_q, pc_d;
  logic [63:0] lsda_q, lsda_d;
  logic [63:0] handle_q, handle_d;
  logic        search_q, search_d;
  logic        ovalid_q;
  lcs_out_t    odata_q;

  logic        fire, emit, emit_req;
  lcs_out_t    res;
  logic [7:0]  b;
  logic        uleb, done;
  logic [63:0] facc, fval, endr;
  logic [6:0]  fshift;
  logic [3:0]  fleft;
  logic [31:0] noff;

  // only an item that brings a result while the held one is stalled must wait
  assign cmd_ready_o = ~(emit_req & ovalid_q & out_stall_i);
  assign fire        = cmd_valid_i & cmd_ready_o;
  assign emit        = fire & emit_req;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;
  assign b           = cmd_data_i.data_byte;
  assign noff        = off_q + 32'd1;

  always_comb begin
    phase_d = phase_q; off_d = off_q; acc_d = acc_q; shift_d = shift_q;
    left_d = left_q; fstart_d = fstart_q; base_enc_d = base_enc_q;
    site_enc_d = site_enc_q; pad_base_d = pad_base_q; tend_d = tend_q;
    estart_d = estart_q; elen_d = elen_q; pc_d = pc_q; lsda_d = lsda_q;
    handle_d = handle_q; search_d = search_q;
    emit_req = 1'b0;
    res  = '{outcome: OutContinue, landing_pad: '0, handler_data: '0};

    // one byte into the current field
    uleb = (phase_q == PhCsLen) ||
           ((phase_q == PhLpPtr) ? (base_enc_q[3:0] == FmtUleb)
                                 : (site_enc_q[3:0] == FmtUleb));
    facc = acc_q; fshift = shift_q; fleft = left_q;
    if (uleb) begin
      if (shift_q < 7'd64) facc = acc_q | ({56'd0, 1'b0, b[6:0]} << shift_q[5:0]);
      if (shift_q < 7'd70) fshift = shift_q + 7'd7;
      done = ~b[7];
    end else begin
      if (shift_q < 7'd64) facc = acc_q | ({56'd0, b} << shift_q[5:0]);
      fshift = shift_q + 7'd8;
      if (left_q != 4'd0) fleft = left_q - 4'd1;
      done = (fleft == 4'd0);
    end
    begin
      logic [7:0] e;
      e = (phase_q == PhLpPtr) ? base_enc_q : site_enc_q;
      fval = facc;
      if (e[3:0] == FmtS2) fval = {{48{facc[15]}}, facc[15:0]};
      if (e[3:0] == FmtS4) fval = {{32{facc[31]}}, facc[31:0]};
      if (e[6:4] == RelPc) fval = fval + lsda_q + {32'd0, fstart_q};
      fval = fval & PtrMask;
    end
    endr = (estart_q + elen_q) & PtrMask;

    if (cmd_valid_i) begin
      if (cmd_data_i.is_start) begin
        if (!cmd_data_i.start_ok) begin
          emit_req = 1'b1; phase_d = PhIdle;
        end else begin
          lsda_d = cmd_data_i.lsda_address; handle_d = cmd_data_i.handle;
          search_d = cmd_data_i.search_phase; pc_d = cmd_data_i.pc_offset;
          pad_base_d = cmd_data_i.region_start;
          base_enc_d = EncOmit; site_enc_d = '0; off_d = '0;
          acc_d = '0; shift_d = '0; left_d = '0; phase_d = PhLpEnc;
        end
      end else if (phase_q != PhIdle) begin
        off_d = noff;
        case (phase_q)
          PhLpEnc: begin
            base_enc_d = b;
            if (b == EncOmit) phase_d = PhTtEnc;
            else if (!enc_ok(b)) begin
              emit_req = 1'b1; res.outcome = OutUnsupported; phase_d = PhIdle;
            end else begin
              phase_d = PhLpPtr; fstart_d = noff; acc_d = '0; shift_d = '0;
              left_d = fixed_size(b, PtrBytes);
            end
          end
          PhLpPtr: begin
            acc_d = facc; shift_d = fshift; left_d = fleft;
            if (done) begin
              if (fval != 64'd0) pad_base_d = fval;
              phase_d = PhTtEnc;
            end
          end
          PhTtEnc: phase_d = (b != EncOmit) ? PhTtSkip : PhCsEnc;
          PhTtSkip: if (!b[7]) phase_d = PhCsEnc;
          PhCsEnc: begin
            site_enc_d = b; phase_d = PhCsLen;
            fstart_d = noff; acc_d = '0; shift_d = '0; left_d = 4'd0;
          end
          PhCsLen: begin
            acc_d = facc; shift_d = fshift; left_d = fleft;
            if (done) begin
              tend_d = noff + facc[31:0];
              if (noff >= noff + facc[31:0]) begin
                emit_req = 1'b1; phase_d = PhIdle;
              end else if (!enc_ok(site_enc_q)) begin
                emit_req = 1'b1; res.outcome = OutUnsupported; phase_d = PhIdle;
              end else if (site_enc_q == EncOmit) begin
                acc_d = '0; estart_d = '0; elen_d = '0; phase_d = PhEAct;
              end else begin
                phase_d = PhEStart; fstart_d = noff; acc_d = '0; shift_d = '0;
                left_d = fixed_size(site_enc_q, PtrBytes);
              end
            end
          end
          PhEStart, PhELen, PhEPad: begin
            acc_d = facc; shift_d = fshift; left_d = fleft;
            if (done) begin
              fstart_d = noff; shift_d = '0;
              left_d = fixed_size(site_enc_q, PtrBytes);
              if (phase_q == PhEStart) begin
                estart_d = fval; acc_d = '0; phase_d = PhELen;
              end else if (phase_q == PhELen) begin
                elen_d = fval; acc_d = '0; phase_d = PhEPad;
              end else begin
                acc_d = fval; phase_d = PhEAct;
              end
            end
          end
          PhEAct: begin
            if (!b[7]) begin
              if ((acc_q != 64'd0) && (estart_q <= pc_q) && (pc_q < endr)) begin
                emit_req = 1'b1; phase_d = PhIdle;
                if (search_q) res.outcome = OutHandler;
                else begin
                  res.outcome = OutInstall;
                  res.landing_pad = (pad_base_q + acc_q) & PtrMask;
                  res.handler_data = handle_q;
                end
              end else if (noff >= tend_q) begin
                emit_req = 1'b1; phase_d = PhIdle;
              end else if (site_enc_q == EncOmit) begin
                acc_d = '0; estart_d = '0; elen_d = '0;
              end else begin
                phase_d = PhEStart; fstart_d = noff; acc_d = '0; shift_d = '0;
                left_d = fixed_size(site_enc_q, PtrBytes);
              end
            end
          end
          default: phase_d = PhIdle;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle; off_q <= '0; acc_q <= '0; shift_q <= '0; left_q <= '0;
      fstart_q <= '0; base_enc_q <= EncOmit; site_enc_q <= '0; pad_base_q <= '0;
      tend_q <= '0; estart_q <= '0; elen_q <= '0; pc_q <= '0; lsda_q <= '0;
      handle_q <= '0; search_q <= 1'b0; ovalid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q <= phase_d; off_q <= off_d; acc_q <= acc_d; shift_q <= shift_d;
        left_q <= left_d; fstart_q <= fstart_d; base_enc_q <= base_enc_d;
        site_enc_q <= site_enc_d; pad_base_q <= pad_base_d; tend_q <= tend_d;
        estart_q <= estart_d; elen_q <= elen_d; pc_q <= pc_d; lsda_q <= lsda_d;
        handle_q <= handle_d; search_q <= search_d;
      end
      if (emit) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) odata_q <= res;
  end

endmodule

// ===== rtl/lsda_call_site_search.sv =====
`timescale 1ns / 1ps
// Call-site table search for one unwind frame. Start and LSDA byte items are
// taken one per cycle: a front stage checks the exception class and LSDA
// presence and works out the pc offset, then a two-entry queue feeds the
// back-end parser, which consumes one byte per cycle through a single
// shift-or field accumulator, 64-bit adds and compares. An accepted item is
// written into the queue and passed on from there to the parser; its result
// is registered before it shows on out_valid_o. Items that bring no result
// keep flowing while a result waits; the parser holds only an item that brings
// a second result while the first is still stalled, and the input stalls once
// the queue behind it is full.
module lsda_call_site_search import lcs_pkg::*; #(
  parameter int unsigned POINTER_BYTES = PointerBytesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [63:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  lcs_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output lcs_out_t    out_data_o
);

  logic [63:0] own_class_q;
  logic        cmd_valid, cmd_ready;
  lcs_cmd_t    cmd_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) own_class_q <= '0;
    else if (cfg_valid_i) own_class_q <= cfg_data_i;
  end

  lcs_front #(.POINTER_BYTES(POINTER_BYTES)) u_front (
    .clk_i, .rst_ni, .own_class_i(own_class_q),
    .in_valid_i, .in_data_i, .in_stall_o,
    .cmd_valid_o(cmd_valid), .cmd_data_o(cmd_data), .cmd_ready_i(cmd_ready)
  );

  lcs_back #(.POINTER_BYTES(POINTER_BYTES)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_data_i(cmd_data),
    .cmd_ready_o(cmd_ready), .out_valid_o, .out_data_o,
    .out_stall_i
  );

endmodule

// ===== rtl/lcs_checker.sv =====
`timescale 1ns / 1ps
`include "lsda_call_site_search_defines.svh"
module lcs_checker import lcs_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_stall_i,
  input logic     out_valid_i,
  input logic     out_stall_i,
  input lcs_out_t out_data_i
);

  logic held, not_install, in_free;

  assign held        = out_valid_i && out_stall_i;
  assign not_install = out_valid_i && (out_data_i.outcome != OutInstall);
  assign in_free     = !in_valid_i && !in_stall_i;

  // a result waiting under stall stays put
  `LCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, held, out_valid_i && $stable(out_data_i))
  // only install_context carries a landing pad
  `LCS_ASSERT_IMPL(a_pad_zero, clk_i, rst_ni, not_install, out_data_i.landing_pad == 64'd0)
  `LCS_ASSERT_IMPL(a_data_zero, clk_i, rst_ni, not_install, out_data_i.handler_data == 64'd0)
  // with room and no transfer coming in, the input stays free
  `LCS_ASSERT_NEXT(a_stall_free, clk_i, rst_ni, in_free, !in_stall_i)

endmodule

bind lsda_call_site_search lcs_checker u_lcs_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .out_valid_i(out_valid_o),
  .out_stall_i, .out_data_i(out_data_o)
);

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import lcs_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  typedef enum logic [3:0] {
    PhIdle, PhLpEnc, PhLpPtr, PhTtEnc, PhTtSkip, PhCsEnc, PhCsLen,
    PhEStart, PhELen, PhEPad, PhEAct
  } parse_phase_e;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  lcs_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  lcs_out_t    out_data;

  lsda_call_site_search DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data)
  );

  always #5 clk_i = ~clk_i;

  lcs_in_t  frame_items[$];
  lcs_out_t expected_verdicts[$];
  int       send_idle_pct = 0;
  int       recv_idle_pct = 0;
  int       errors = 0;
  int       cycles = 0;

  // predictor state
  logic [63:0]  own_class = '0;
  parse_phase_e ph = PhIdle;
  logic [31:0]  boff, fstart, tend;
  logic [63:0]  acc, pbase, estart, elen, pco, flsda, fhandle;
  int           shf, left;
  logic [7:0]   benc = EncOmit, senc;
  logic         fsearch;

  function automatic bit enc_good(input logic [7:0] e);
    if (e == EncOmit) return 1'b1;
    if (!(e[3:0] <= FmtU8 || e[3:0] == FmtS2 || e[3:0] == FmtS4 || e[3:0] == FmtS8))
      return 1'b0;
    return e[6:4] == RelAbs || e[6:4] == RelPc;
  endfunction

  function automatic int width_of(input logic [7:0] e);
    case (e[3:0])
      FmtPtr: return int'(PointerBytesDefault);
      FmtU2, FmtS2: return 2;
      FmtU4, FmtS4: return 4;
      FmtU8, FmtS8: return 8;
      default: return 0;
    endcase
  endfunction

  task automatic open_field(input logic [7:0] e);
    fstart = boff;
    acc = '0;
    shf = 0;
    left = width_of(e);
  endtask

  function automatic bit take_byte(input logic [7:0] b, input bit uleb);
    if (uleb) begin
      if (shf < 64) acc = acc | ({57'd0, b[6:0]} << shf);
      if (shf < 70) shf += 7;
      return !b[7];
    end
    if (shf < 64) acc = acc | ({56'd0, b} << shf);
    shf += 8;
    if (left > 0) left--;
    return left == 0;
  endfunction

  function automatic logic [63:0] field_value(input logic [7:0] e);
    logic [63:0] v;
    v = acc;
    if (e[3:0] == FmtS2) v = {{48{v[15]}}, v[15:0]};
    if (e[3:0] == FmtS4) v = {{32{v[31]}}, v[31:0]};
    if (e[6:4] == RelPc) v = v + flsda + {32'd0, fstart};
    return v;
  endfunction

  task automatic go_phase(input parse_phase_e p);
    forever begin
      ph = p;
      if (p == PhLpPtr) begin open_field(benc); return; end
      if (p == PhCsLen) begin open_field(EncUleb); return; end
      if (p < PhEStart || p > PhEPad) return;
      if (senc != EncOmit) begin open_field(senc); return; end
      // omitted site encoding: zero-length fields equal to zero
      acc = '0;
      if (p == PhEStart) estart = '0;
      else if (p == PhELen) elen = '0;
      p = parse_phase_e'(p + 1);
    end
  endtask

  task automatic verdict(input logic [1:0] oc, input logic [63:0] lp, input logic [63:0] hd);
    lcs_out_t r;
    r.outcome = oc;
    r.landing_pad = lp;
    r.handler_data = hd;
    expected_verdicts.push_back(r);
    ph = PhIdle;
  endtask

  task automatic search_step(input lcs_in_t it);
    logic [7:0]  b;
    logic [63:0] v;
    if (!it.action) begin
      ph = PhIdle;
      if (it.exc_class != own_class || !it.lsda_present) begin
        verdict(OutContinue, '0, '0);
        return;
      end
      flsda = it.lsda_address;
      fhandle = it.exception_handle;
      fsearch = it.search_phase;
      pco = it.return_address - 64'd1 - it.region_start;
      pbase = it.region_start;
      benc = EncOmit;
      senc = '0;
      boff = '0;
      acc = '0;
      shf = 0;
      left = 0;
      ph = PhLpEnc;
      return;
    end
    if (ph == PhIdle) return;
    b = it.data_byte;
    boff++;
    case (ph)
      PhLpEnc: begin
        benc = b;
        if (b == EncOmit) go_phase(PhTtEnc);
        else if (!enc_good(b)) verdict(OutUnsupported, '0, '0);
        else go_phase(PhLpPtr);
      end
      PhLpPtr: begin
        if (take_byte(b, benc[3:0] == FmtUleb)) begin
          v = field_value(benc);
          if (v != 0) pbase = v;
          go_phase(PhTtEnc);
        end
      end
      PhTtEnc: go_phase(b != EncOmit ? PhTtSkip : PhCsEnc);
      PhTtSkip: if (!b[7]) go_phase(PhCsEnc);
      PhCsEnc: begin
        senc = b;
        go_phase(PhCsLen);
      end
      PhCsLen: begin
        if (take_byte(b, 1'b1)) begin
          tend = boff + acc[31:0];
          if (boff >= tend) verdict(OutContinue, '0, '0);
          else if (!enc_good(senc)) verdict(OutUnsupported, '0, '0);
          else go_phase(PhEStart);
        end
      end
      PhEStart, PhELen, PhEPad: begin
        if (take_byte(b, senc[3:0] == FmtUleb)) begin
          v = field_value(senc);
          if (ph == PhEStart) begin
            estart = v;
            go_phase(PhELen);
          end else if (ph == PhELen) begin
            elen = v;
            go_phase(PhEPad);
          end else begin
            acc = v;
            go_phase(PhEAct);
          end
        end
      end
      PhEAct: begin
        if (!b[7]) begin
          if (acc != 0 && estart <= pco && pco < estart + elen) begin
            if (fsearch) verdict(OutHandler, '0, '0);
            else verdict(OutInstall, pbase + acc, fhandle);
          end else if (boff >= tend) begin
            verdict(OutContinue, '0, '0);
          end else begin
            go_phase(PhEStart);
          end
        end
      end
      default: ph = PhIdle;
    endcase
  endtask

  // sender: accepted transfers go through the predictor
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall) search_step(in_data);
      if (!in_valid || !in_stall) begin
        if (frame_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data <= frame_items.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk_i) begin
    lcs_out_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        if (expected_verdicts.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
        end else begin
          want = expected_verdicts.pop_front();
          if (out_data.outcome !== want.outcome) begin
            errors++;
            $display("%0t: outcome expected %0d actual %0d", $time, want.outcome,
                     out_data.outcome);
          end
          if (out_data.landing_pad !== want.landing_pad) begin
            errors++;
            $display("%0t: landing_pad expected %h actual %h", $time, want.landing_pad,
                     out_data.landing_pad);
          end
          if (out_data.handler_data !== want.handler_data) begin
            errors++;
            $display("%0t: handler_data expected %h actual %h", $time, want.handler_data,
                     out_data.handler_data);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic lcs_in_t byte_item(input logic [7:0] b);
    lcs_in_t      it;
    logic [351:0] r;
    r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
         $urandom, $urandom, $urandom, $urandom};
    it = r[$bits(lcs_in_t)-1:0];
    it.action = 1'b1;
    it.data_byte = b;
    return it;
  endfunction

  task automatic put_uleb(inout logic [7:0] bytes[$], input logic [63:0] v,
                          input int extra, input bit junk);
    int n;
    logic [63:0] t;
    logic [7:0] b;
    n = 1;
    t = v >> 7;
    while (t != 0) begin
      n++;
      t = t >> 7;
    end
    n += extra;
    for (int i = 0; i < n; i++) begin
      b = {1'b0, v[6:0]};
      if (v == 0 && junk) b[6:0] = 7'($urandom_range(127));
      v = v >> 7;
      if (i < n - 1) b[7] = 1'b1;
      bytes.push_back(b);
    end
  endtask

  task automatic put_field(inout logic [7:0] bytes[$], input logic [7:0] e,
                           input logic [63:0] v);
    int n;
    if (e == EncOmit) return;
    if (e[3:0] == FmtUleb) begin
      put_uleb(bytes, v, ($urandom_range(9) == 0) ? int'($urandom_range(1, 6)) : 0,
               $urandom_range(3) == 0);
      return;
    end
    n = width_of(e);
    for (int i = 0; i < n; i++) bytes.push_back(v[8*i +: 8]);
  endtask

  function automatic logic [7:0] pick_enc(input bit allow_bad);
    logic [7:0] good[13] = '{8'hff, 8'h00, 8'h01, 8'h02, 8'h03, 8'h04, 8'h0a,
                             8'h0b, 8'h0c, 8'h11, 8'h13, 8'h9b, 8'h81};
    logic [7:0] bad[6] = '{8'h09, 8'h0d, 8'h21, 8'h31, 8'h0f, 8'h75};
    if (allow_bad && $urandom_range(15) == 0) return bad[$urandom_range(5)];
    return good[$urandom_range(12)];
  endfunction

  // kind: 0 well formed, 1 foreign class, 2 no lsda, 3 cut short,
  //       4 wrong table length, 5 long table length
  task automatic queue_frame(input logic [7:0] be, input logic [7:0] se,
                             input int entries, input int kind);
    lcs_in_t     st;
    logic [7:0]  lsda[$], table_bytes[$];
    logic [63:0] po, lp, tl;
    int          cut;
    st = byte_item(8'($urandom));
    st.action = 1'b0;
    po = 64'($urandom_range(400));
    st.return_address = st.region_start + 64'd1 + po;
    st.exc_class = (kind == 1) ? ((($urandom_range(1) == 0) ? own_class ^
                   (64'd1 << $urandom_range(63)) : rand64())) : own_class;
    st.lsda_present = (kind != 2);
    frame_items.push_back(st);
    if (kind == 1 || kind == 2) return;
    lsda.push_back(be);
    if (be != EncOmit) begin
      lp = ($urandom_range(4) == 0) ? 64'd0 : rand64();
      put_field(lsda, be, lp);
    end
    if ($urandom_range(1)) begin
      lsda.push_back(EncOmit);
    end else begin
      lsda.push_back(8'h9b);
      put_uleb(lsda, 64'($urandom_range(3000)), int'($urandom_range(2)), 1'b0);
    end
    lsda.push_back(se);
    for (int i = 0; i < entries; i++) begin
      put_field(table_bytes, se, 64'($urandom_range(0, 420)));
      put_field(table_bytes, se,
                ($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(130)));
      put_field(table_bytes, se, ($urandom_range(4) == 0) ? 64'd0 : rand64());
      put_uleb(table_bytes, 64'($urandom_range(300)), int'($urandom_range(1)), 1'b0);
    end
    tl = 64'(table_bytes.size());
    if (kind == 4) tl = 64'($urandom_range(60));
    put_uleb(lsda, tl, (kind == 5) ? int'($urandom_range(8, 12)) : 0, kind == 5);
    foreach (table_bytes[i]) lsda.push_back(table_bytes[i]);
    cut = (kind == 3) ? int'($urandom_range(lsda.size())) : lsda.size();
    for (int i = 0; i < cut; i++) frame_items.push_back(byte_item(lsda[i]));
  endtask

  task automatic queue_random_frame();
    int kind, r;
    r = $urandom_range(99);
    kind = (r < 78) ? 0 : (r < 82) ? 1 : (r < 85) ? 2 : (r < 91) ? 3 : (r < 96) ? 4 : 5;
    // stray bytes, ignored while idle or landing in a cut-short frame
    if ($urandom_range(9) == 0)
      repeat ($urandom_range(1, 4)) frame_items.push_back(byte_item(8'($urandom)));
    queue_frame(pick_enc(1'b1), pick_enc(1'b1), $urandom_range(0, 6), kind);
  endtask

  task automatic settle();
    while (frame_items.size() > 0 || in_valid || expected_verdicts.size() > 0)
      @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic write_own_class(input logic [63:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk_i); while (!cfg_ready);
    own_class = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_stretch(input int n_items);
    int target;
    target = n_items;
    while (target > 0) begin
      int before_sz;
      before_sz = frame_items.size();
      queue_random_frame();
      target -= frame_items.size() - before_sz;
      while (frame_items.size() > 30) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    write_own_class(rand64());
    send_idle_pct = 22;
    recv_idle_pct = 45;

    // bytes with no frame open
    frame_items.push_back(byte_item(8'h00));
    frame_items.push_back(byte_item(8'hff));
    queue_frame(EncOmit, EncUleb, 3, 0);
    queue_frame(8'h00, 8'h03, 2, 0);
    queue_frame(8'h1b, 8'h0c, 2, 0);
    queue_frame(8'h0a, 8'h02, 2, 0);
    queue_frame(8'h04, 8'h0b, 1, 0);
    queue_frame(8'h11, 8'h13, 2, 0);
    queue_frame(EncOmit, EncOmit, 3, 0);
    queue_frame(8'h09, EncUleb, 1, 0);
    queue_frame(8'h21, EncUleb, 1, 0);
    queue_frame(EncOmit, 8'h09, 1, 0);
    queue_frame(EncOmit, 8'h0d, 0, 0);
    queue_frame(EncOmit, EncUleb, 0, 0);
    queue_frame(EncOmit, EncUleb, 2, 1);
    queue_frame(EncOmit, EncUleb, 2, 2);
    queue_frame(EncOmit, EncUleb, 4, 3);
    queue_frame(EncOmit, EncUleb, 2, 5);
    queue_frame(8'h81, 8'h83, 3, 4);
    settle();

    random_stretch(140);
    settle();
    random_stretch(140);
    settle();

    write_own_class('1);
    send_idle_pct = 45;
    recv_idle_pct = 22;
    random_stretch(260);
    settle();

    write_own_class('0);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_stretch(260);
    settle();

    errors += expected_verdicts.size();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
